### rtl/apr_pkg.sv
// ----------------------------------------------------------------------------
// apr_pkg
// Shared sizes, types and codes for the aging page replacement block.
// ----------------------------------------------------------------------------
package apr_pkg;

    localparam int FRAMES    = 16;
    localparam int AGE_BITS  = 8;
    localparam int PAGE_BITS = 16;
    localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FIF_W     = 5;
    localparam int HB_W      = 3;
    localparam int CFG_W     = 5;
    localparam int CIDX_W    = 1;
    localparam int FAULT_W   = 32;
    localparam int OUT_IDX_W = 4;

    localparam logic [FIF_W-1:0] FIF_RESET = FIF_W'(16);
    localparam logic [HB_W-1:0]  HB_RESET  = HB_W'(6);

    localparam logic [CIDX_W-1:0] CFG_FRAMES_IN_USE = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_HISTORY_BIT   = 1'b1;

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [AGE_BITS-1:0]  age_t;
    typedef logic [PAGE_BITS-1:0] page_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
    } sts_t;

endpackage

### rtl/aging_page_replacement.sv
// ----------------------------------------------------------------------------
// aging_page_replacement
// Aging page replacement over a frame table, one page reference per command.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------------
//  config    | cfg_we               | cfg_index, cfg_data
//  reference | start, busy          | page_number, last_request
//  result    | done (one cycle)     | hit, frame_index, fault_count
//
//  A reference runs from start to the next start as follows, where n is
//  frames_in_use held to 1..16: the accepting cycle loads it, the scan visits
//  one frame per cycle over n frames, then the update state writes the table,
//  and the result shows with done in the cycle that follows, when busy is
//  already low. Reset clears the valid marks, aging registers and fault count
//  at once; there is no clearing pass. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module aging_page_replacement (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [apr_pkg::CIDX_W-1:0]     cfg_index,
    input  logic [apr_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           start,
    input  logic [apr_pkg::PAGE_BITS-1:0]  page_number,
    input  logic                           last_request,
    output logic                           busy,
    output logic                           done,
    output logic                           hit,
    output logic [apr_pkg::OUT_IDX_W-1:0]  frame_index,
    output logic [apr_pkg::FAULT_W-1:0]    fault_count
);
    import apr_pkg::*;

    cmd_t cmd;
    sts_t sts;

    apr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    apr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .page_number  (page_number),
        .last_request (last_request),
        .cmd          (cmd),
        .sts          (sts),
        .hit          (hit),
        .frame_index  (frame_index),
        .fault_count  (fault_count)
    );

endmodule

### rtl/apr_ctrl.sv
// ----------------------------------------------------------------------------
// apr_ctrl
// Sequencer: takes a reference, steps the frame scan, then the table update.
// ----------------------------------------------------------------------------
module apr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  apr_pkg::sts_t sts,
    output apr_pkg::cmd_t cmd,
    output logic          busy,
    output logic          done
);
    import apr_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.update;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

### rtl/apr_dp.sv
// ----------------------------------------------------------------------------
// apr_dp
// Frame table, configuration registers, scan registers and result registers.
// ----------------------------------------------------------------------------
module apr_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [apr_pkg::CIDX_W-1:0]     cfg_index,
    input  logic [apr_pkg::CFG_W-1:0]      cfg_data,
    input  logic [apr_pkg::PAGE_BITS-1:0]  page_number,
    input  logic                           last_request,
    input  apr_pkg::cmd_t                  cmd,
    output apr_pkg::sts_t                  sts,
    output logic                           hit,
    output logic [apr_pkg::OUT_IDX_W-1:0]  frame_index,
    output logic [apr_pkg::FAULT_W-1:0]    fault_count
);
    import apr_pkg::*;

    logic [FIF_W-1:0]   frames_in_use_reg;
    logic [HB_W-1:0]    history_bit_reg;

    page_t              tag_reg   [FRAMES];
    logic [FRAMES-1:0]  valid_reg;
    age_t               age_reg   [FRAMES];

    page_t              page_reg;
    logic               last_reg;
    idx_t               last_idx_reg;
    age_t               mask_reg;
    idx_t               idx_reg;
    logic               hit_reg;
    idx_t               hit_idx_reg;
    idx_t               min_idx_reg;
    age_t               min_age_reg;
    logic [FAULT_W-1:0] faults_reg;

    logic               hit_out_reg;
    logic [OUT_IDX_W-1:0] frame_out_reg;
    logic [FAULT_W-1:0] fault_out_reg;

    idx_t               last_idx_next;
    age_t               mask_next;
    age_t               shifted;
    logic               match;
    logic [FAULT_W-1:0] faults_next;
    idx_t               chosen;

    // Clamp the frame count to 1..FRAMES and the history bit to the register.
    always_comb
    begin
        if (frames_in_use_reg == '0)
        begin
            last_idx_next = '0;
        end
        else if (32'(frames_in_use_reg) > FRAMES)
        begin
            last_idx_next = IDX_W'(FRAMES - 1);
        end
        else
        begin
            last_idx_next = IDX_W'(frames_in_use_reg - FIF_W'(1));
        end

        if (32'(history_bit_reg) >= AGE_BITS)
        begin
            mask_next = age_t'(1) << (AGE_BITS - 1);
        end
        else
        begin
            mask_next = age_t'(1) << history_bit_reg;
        end
    end

    // One frame per scan cycle: age it, look for the first match, track the minimum.
    assign shifted = age_reg[idx_reg] >> 1;
    assign match   = valid_reg[idx_reg] && (tag_reg[idx_reg] == page_reg) && !hit_reg;
    assign sts.scan_done = (idx_reg == last_idx_reg);

    always_comb
    begin
        if (hit_reg)
        begin
            faults_next = faults_reg;
        end
        else if (faults_reg != '1)
        begin
            faults_next = faults_reg + FAULT_W'(1);
        end
        else
        begin
            faults_next = faults_reg;
        end
        chosen = hit_reg ? hit_idx_reg : min_idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= FIF_RESET;
            history_bit_reg   <= HB_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAMES_IN_USE: frames_in_use_reg <= cfg_data[FIF_W-1:0];
                CFG_HISTORY_BIT:   history_bit_reg   <= cfg_data[HB_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            age_reg   <= '{default: '0};
        end
        else if (cmd.scan)
        begin
            age_reg[idx_reg] <= match ? (shifted | mask_reg) : shifted;
        end
        else if (cmd.update && !hit_reg)
        begin
            age_reg[min_idx_reg]   <= mask_reg;
            valid_reg[min_idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update && !hit_reg)
        begin
            tag_reg[min_idx_reg] <= page_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            hit_reg      <= 1'b0;
            hit_idx_reg  <= '0;
            min_idx_reg  <= '0;
            min_age_reg  <= '0;
            faults_reg   <= '0;
            last_idx_reg <= '0;
            mask_reg     <= '0;
            last_reg     <= 1'b0;
        end
        else if (cmd.load)
        begin
            idx_reg      <= '0;
            hit_reg      <= 1'b0;
            hit_idx_reg  <= '0;
            min_idx_reg  <= '0;
            last_idx_reg <= last_idx_next;
            mask_reg     <= mask_next;
            last_reg     <= last_request;
        end
        else if (cmd.scan)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
            if (match)
            begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= idx_reg;
            end
            // Strict compare keeps the lowest index on ties.
            if ((idx_reg == '0) || (shifted < min_age_reg))
            begin
                min_age_reg <= shifted;
                min_idx_reg <= idx_reg;
            end
        end
        else if (cmd.update)
        begin
            faults_reg <= last_reg ? '0 : faults_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg <= page_number;
        end
        if (cmd.update)
        begin
            hit_out_reg   <= hit_reg;
            frame_out_reg <= OUT_IDX_W'(chosen);
            fault_out_reg <= faults_next;
        end
    end

    assign hit         = hit_out_reg;
    assign frame_index = frame_out_reg;
    assign fault_count = fault_out_reg;

endmodule

### rtl/apr_checker.sv
// ----------------------------------------------------------------------------
// apr_checker
// Port-level checks on command, busy and result timing.
// ----------------------------------------------------------------------------
module apr_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           done,
    input logic                           hit,
    input logic [apr_pkg::FAULT_W-1:0]    fault_count
);
    import apr_pkg::*;

    // An accepted command keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    // The result appears only once the block has gone idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // One result per transfer, never in back-to-back cycles.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // A fault always leaves a nonzero count in the result.
    a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> fault_count != '0)
        else $error("fault reported with zero count");

endmodule

bind aging_page_replacement apr_checker u_apr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .hit         (hit),
    .fault_count (fault_count)
);

### verif/aging_page_replacement_tb.sv
// ----------------------------------------------------------------------------
// aging_page_replacement_tb
// Self-checking bench for the aging page replacement block. A tracker keeps
// its own copy of the frame table, aging registers and fault count, predicts
// hit, frame and fault count for every accepted reference, and compares them
// with each done pulse. A short directed opening is followed by phases with
// fixed, then random settings, working-set page streams and idle bursts.
// ----------------------------------------------------------------------------
module aging_page_replacement_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import apr_pkg::*;

    localparam int TOTAL_REFS   = 1300;
    localparam int QUIET_TAIL   = 150;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic                 hit;
        logic [OUT_IDX_W-1:0] frame;
        logic [FAULT_W-1:0]   faults;
    } outcome_t;

    class frame_table_tracker;
        logic [CFG_W-1:0]   frames_cfg;
        logic [HB_W-1:0]    hist_cfg;
        page_t              tags [FRAMES];
        bit                 valid [FRAMES];
        age_t               ages [FRAMES];
        logic [FAULT_W-1:0] faults;
        outcome_t           expected_outcomes [$];
        int                 mismatches;
        int                 checked;
        int                 hits_seen;

        function new();
            frames_cfg = FIF_RESET;
            hist_cfg   = HB_RESET;
            for (int i = 0; i < FRAMES; i++)
            begin
                tags[i]  = '0;
                valid[i] = 1'b0;
                ages[i]  = '0;
            end
            faults     = '0;
            mismatches = 0;
            checked    = 0;
            hits_seen  = 0;
        endfunction

        function void write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_FRAMES_IN_USE)
                frames_cfg = data;
            else if (idx == CFG_HISTORY_BIT)
                hist_cfg = data[HB_W-1:0];
        endfunction

        function void note_reference(page_t page, logic last);
            int       n;
            int       pos;
            int       chosen;
            bit       found;
            age_t     mark;
            outcome_t o;
            n = int'(frames_cfg);
            if (n == 0)
                n = 1;
            if (n > FRAMES)
                n = FRAMES;
            pos  = (int'(hist_cfg) >= AGE_BITS) ? AGE_BITS - 1 : int'(hist_cfg);
            mark = age_t'(1) << pos;
            for (int i = 0; i < n; i++)
                ages[i] = ages[i] >> 1;
            found  = 1'b0;
            chosen = 0;
            for (int i = 0; i < n && !found; i++)
            begin
                if (valid[i] && tags[i] == page)
                begin
                    found  = 1'b1;
                    chosen = i;
                end
            end
            if (found)
            begin
                ages[chosen] = ages[chosen] | mark;
            end
            else
            begin
                // Strictly smaller only, so ties stay with the lowest frame.
                for (int i = 1; i < n; i++)
                    if (ages[i] < ages[chosen])
                        chosen = i;
                tags[chosen]  = page;
                valid[chosen] = 1'b1;
                ages[chosen]  = mark;
                if (faults != '1)
                    faults = faults + 1'b1;
            end
            o.hit    = found;
            o.frame  = OUT_IDX_W'(chosen);
            o.faults = faults;
            expected_outcomes.push_back(o);
            if (last)
                faults = '0;
        endfunction

        function int pending();
            return expected_outcomes.size();
        endfunction

        function void check_outcome(logic hit, logic [OUT_IDX_W-1:0] frame,
                                    logic [FAULT_W-1:0] count);
            outcome_t o;
            if (expected_outcomes.size() == 0)
            begin
                $error("result transfer with no reference outstanding");
                mismatches++;
                return;
            end
            o = expected_outcomes.pop_front();
            checked++;
            if (o.hit)
                hits_seen++;
            if (hit !== o.hit)
            begin
                $error("hit: expected %0d, got %0d", o.hit, hit);
                mismatches++;
            end
            if (frame !== o.frame)
            begin
                $error("frame_index: expected %0d, got %0d", o.frame, frame);
                mismatches++;
            end
            if (count !== o.faults)
            begin
                $error("fault_count: expected %0d, got %0d", o.faults, count);
                mismatches++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CIDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 start;
    page_t                page_number;
    logic                 last_request;
    logic                 busy;
    logic                 done;
    logic                 hit;
    logic [OUT_IDX_W-1:0] frame_index;
    logic [FAULT_W-1:0]   fault_count;

    frame_table_tracker sb;
    int                 refs_sent;
    int                 settings_used;
    int                 cycles;

    aging_page_replacement u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .page_number  (page_number),
        .last_request (last_request),
        .busy         (busy),
        .done         (done),
        .hit          (hit),
        .frame_index  (frame_index),
        .fault_count  (fault_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_outcome(hit, frame_index, fault_count);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("aging_page_replacement: mismatch");
            $finish;
        end
    end

    // Holds the reference until the block takes it; a nonzero gap first keeps
    // start low until the block is free again and the gap has run out.
    task automatic send_reference(input page_t page, input logic last, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while (busy);
            repeat (gap - 1) @(posedge clk);
        end
        start        <= 1'b1;
        page_number  <= page;
        last_request <= last;
        do
            @(posedge clk);
        while (busy);
        sb.note_reference(page, last);
        refs_sent++;
    endtask

    task automatic settle();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] frames,
                                input logic [CFG_W-1:0] hist);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FRAMES_IN_USE;
        cfg_data  <= frames;
        @(posedge clk);
        sb.write_reg(CFG_FRAMES_IN_USE, frames);
        cfg_index <= CFG_HISTORY_BIT;
        cfg_data  <= hist;
        @(posedge clk);
        sb.write_reg(CFG_HISTORY_BIT, hist);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Mostly pages from a sliding working set so hits are common.
    function automatic page_t pick_page(page_t base, int span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return base + page_t'($urandom_range(0, span - 1));
        else if (r < 78)
            return '0;
        else if (r < 81)
            return '1;
        else
            return page_t'($urandom);
    endfunction

    initial
    begin
        logic [CFG_W-1:0] frames_sel;
        logic [CFG_W-1:0] hist_sel;
        int               phase;
        int               batch;
        int               span;
        int               gap;
        bit               idle_on;
        page_t            base;

        sb            = new();
        refs_sent     = 0;
        settings_used = 0;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        start        <= 1'b0;
        page_number  <= '0;
        last_request <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty frames must not match page zero; the run ends on a hit.
        send_reference(16'h0000, 1'b0, 0);
        send_reference(16'h0000, 1'b0, 0);
        send_reference(16'hFFFF, 1'b0, 0);
        send_reference(16'hFFFF, 1'b1, 0);
        for (int i = 0; i < 12; i++)
            send_reference(page_t'(16'h0100 + i), 1'b0, 0);
        // One frame in use (written as zero): the page lands in frame 0 while
        // an older copy sits in an idle frame.
        settle();
        write_config(5'd0, 5'd7);
        send_reference(16'h0105, 1'b0, 0);
        // Oversized frame count: two frames hold the page, the lower one wins.
        settle();
        write_config(5'd31, 5'd0);
        send_reference(16'h0105, 1'b1, 0);

        phase = 0;
        while (refs_sent < TOTAL_REFS)
        begin
            case (phase)
                0: begin frames_sel = 5'd1;  hist_sel = 5'd0; end
                1: begin frames_sel = 5'd16; hist_sel = 5'd7; end
                2: begin frames_sel = 5'd0;  hist_sel = 5'd3; end
                3: begin frames_sel = 5'd31; hist_sel = 5'd5; end
                default:
                begin
                    frames_sel = CFG_W'($urandom_range(0, 31));
                    hist_sel   = CFG_W'($urandom_range(0, 7));
                end
            endcase
            phase++;
            settle();
            write_config(frames_sel, hist_sel);
            batch   = $urandom_range(40, 120);
            span    = $urandom_range(1, 2 * FRAMES + 2);
            base    = page_t'($urandom);
            idle_on = (refs_sent < TOTAL_REFS - QUIET_TAIL) && ($urandom_range(0, 2) != 0);
            for (int j = 0; j < batch && refs_sent < TOTAL_REFS; j++)
            begin
                gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
                if ($urandom_range(0, 19) == 0)
                    base = page_t'($urandom);
                send_reference(pick_page(base, span), $urandom_range(0, 29) == 0, gap);
            end
        end

        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Sent %0d page references over %0d register settings;", refs_sent,
                 settings_used);
        $display("checked %0d results, %0d of them hits.", sb.checked, sb.hits_seen);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("aging_page_replacement: match");
        else
            $display("aging_page_replacement: mismatch");
        $finish;
    end

endmodule

### filelist.f
rtl/apr_pkg.sv
rtl/apr_ctrl.sv
rtl/apr_dp.sv
rtl/aging_page_replacement.sv
rtl/apr_checker.sv
verif/aging_page_replacement_tb.sv
